/* rtl/core/blfs_pkg.sv */
`default_nettype none

package blfs_pkg;

	// Field and state widths.
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned STEP_W    = 16;
	localparam int unsigned REPEAT_W  = 8;
	localparam int unsigned GAP_W     = 16;
	localparam int unsigned SEL_W     = 2;
	localparam int unsigned LED_W     = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned DUTY_W    = 18;
	localparam int unsigned PHASE_W   = 17;
	localparam int unsigned PRESC_W   = 10;

	// Microsecond ticks that make up one millisecond of gap time.
	localparam logic [PRESC_W:0] US_PER_MS = 11'd1000;

	// Register reset values.
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
	localparam logic [STEP_W-1:0]   STEP_RST   = 16'd10;
	localparam logic [REPEAT_W-1:0] REPEAT_RST = 8'd1;
	localparam logic [GAP_W-1:0]    GAP_RST    = 16'd500;
	localparam logic [SEL_W-1:0]    SEL_RST    = 2'd0;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 3'd0,
		REG_STEP   = 3'd1,
		REG_REPEAT = 3'd2,
		REG_GAP    = 3'd3,
		REG_SELECT = 3'd4
	} cfg_reg_t;

	// Input word kinds.
	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_START = 1'b1
	} item_kind_t;

endpackage

`default_nettype wire

/* rtl/core/breathing_led_fade_sequencer.sv */
`default_nettype none

// Breathing LED fade sequencer. Each input word is either a one-microsecond
// tick or a start request; every input word produces exactly one output word
// that shows the LED drive (bit led_select of led_lines set while lit) and
// whether a blink sequence is running. A blink starts at duty 0, toggles the
// LED at each phase boundary once the duty is above zero, and, at boundaries
// hit by a tick word with ramp_enable set, ramps the duty up by duty_step_us
// until it reaches period_us and then back down; it ends when the duty would
// reach zero. A sequence is repeat_count blinks separated by gaps of gap_ms
// milliseconds. Start requests while busy are ignored. One word per clock is
// taken while the output is not stalled: a word sits in the input register
// while the state update is computed, and its result is loaded into the
// output register once that register is empty or being drained. The input
// side stalls only when both registers hold a word and the output is
// stalled. Configuration writes are meant to happen while the block is idle;
// a write while a sequence runs takes effect at the register's next use.
module breathing_led_fade_sequencer
	import blfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input channel.
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 kind,
	input  wire logic                 ramp_enable,
	// Output channel.
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [LED_W-1:0]          led_lines,
	output logic                      busy_res,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	// Configuration registers.
	logic [PERIOD_W-1:0] period_q;
	logic [STEP_W-1:0]   step_q;
	logic [REPEAT_W-1:0] repeat_q;
	logic [GAP_W-1:0]    gap_q;
	logic [SEL_W-1:0]    select_q;

	// Input register.
	logic valid_s1;
	logic kind_s1;
	logic ramp_s1;

	// Sequencer state.
	logic [DUTY_W-1:0]   duty_q;
	logic                ramp_down_q;
	logic                lit_q;
	logic [PHASE_W-1:0]  elapsed_q;
	logic [PHASE_W-1:0]  length_q;
	logic                blink_q;
	logic                seq_q;
	logic [REPEAT_W-1:0] blinks_q;
	logic                gap_act_q;
	logic [GAP_W-1:0]    gap_left_q;
	logic [PRESC_W-1:0]  presc_q;

	// Output register.
	logic             out_valid_q;
	logic [LED_W-1:0] led_q;
	logic             busy_q;

	// Next state.
	logic [DUTY_W-1:0]   duty_n;
	logic                ramp_down_n;
	logic                lit_n;
	logic [PHASE_W-1:0]  elapsed_n;
	logic [PHASE_W-1:0]  length_n;
	logic                blink_n;
	logic                seq_n;
	logic [REPEAT_W-1:0] blinks_n;
	logic                gap_act_n;
	logic [GAP_W-1:0]    gap_left_n;
	logic [PRESC_W-1:0]  presc_n;

	logic advance;
	logic fire;

	// The word in the input register moves on whenever the output register
	// is empty or being drained this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			step_q   <= STEP_RST;
			repeat_q <= REPEAT_RST;
			gap_q    <= GAP_RST;
			select_q <= SEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				REG_REPEAT: repeat_q <= cfg_data[REPEAT_W-1:0];
				REG_GAP:    gap_q    <= cfg_data[GAP_W-1:0];
				REG_SELECT: select_q <= cfg_data[SEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			ramp_s1 <= ramp_enable;
		end
	end

	// State update for one word. A boundary sets up the next phase (stepping
	// the duty first when ramping) or ends the blink; ending a blink may start
	// the next one at once (zero gap), and that restart is applied last.
	always_comb begin
		logic [DUTY_W-1:0]   tick_next;
		logic [PRESC_W:0]    presc_inc;
		logic [REPEAT_W-1:0] blinks_inc;
		logic                boundary;
		logic                finish;
		logic                restart;

		duty_n      = duty_q;
		ramp_down_n = ramp_down_q;
		lit_n       = lit_q;
		elapsed_n   = elapsed_q;
		length_n    = length_q;
		blink_n     = blink_q;
		seq_n       = seq_q;
		blinks_n    = blinks_q;
		gap_act_n   = gap_act_q;
		gap_left_n  = gap_left_q;
		presc_n     = presc_q;

		tick_next  = {1'b0, elapsed_q} + 1'b1;
		presc_inc  = {1'b0, presc_q} + 1'b1;
		blinks_inc = blinks_q + 1'b1;
		boundary   = 1'b0;
		finish     = 1'b0;
		restart    = 1'b0;

		if (fire) begin
			if (item_kind_t'(kind_s1) == KIND_START) begin
				if (!seq_q && repeat_q != '0) begin
					seq_n    = 1'b1;
					blinks_n = '0;
					restart  = 1'b1;
				end
			end else if (seq_q) begin
				if (blink_q) begin
					if (tick_next >= {1'b0, length_q}) begin
						boundary = 1'b1;
					end else begin
						elapsed_n = tick_next[PHASE_W-1:0];
					end
				end else if (gap_act_q) begin
					if (presc_inc >= US_PER_MS) begin
						presc_n = '0;
						if (gap_left_q != '0) begin
							gap_left_n = gap_left_q - 1'b1;
						end
						if (gap_left_n == '0) begin
							restart = 1'b1;
						end
					end else begin
						presc_n = presc_inc[PRESC_W-1:0];
					end
				end else begin
					restart = 1'b1;
				end
			end
		end

		if (boundary) begin
			if (duty_q != '0) begin
				lit_n = !lit_q;
			end
			if (ramp_s1) begin
				if (!ramp_down_q && duty_q >= DUTY_W'(period_q)) begin
					ramp_down_n = 1'b1;
				end
				if (!ramp_down_n) begin
					duty_n = duty_q + DUTY_W'(step_q);
				end else if (DUTY_W'(step_q) >= duty_q) begin
					finish = 1'b1;
				end else begin
					duty_n = duty_q - DUTY_W'(step_q);
				end
			end
			if (!finish) begin
				if (lit_n) begin
					length_n = duty_n[PHASE_W-1:0];
				end else if (duty_n >= DUTY_W'(period_q)) begin
					length_n = '0;
				end else begin
					length_n = PHASE_W'(DUTY_W'(period_q) - duty_n);
				end
				elapsed_n = '0;
			end
		end

		if (finish) begin
			duty_n      = '0;
			ramp_down_n = 1'b0;
			lit_n       = 1'b0;
			elapsed_n   = '0;
			length_n    = '0;
			blink_n     = 1'b0;
			blinks_n    = blinks_inc;
			if (blinks_inc < repeat_q && blinks_inc != '0) begin
				if (gap_q == '0) begin
					restart = 1'b1;
				end else begin
					gap_act_n  = 1'b1;
					gap_left_n = gap_q;
					presc_n    = '0;
				end
			end else begin
				seq_n     = 1'b0;
				gap_act_n = 1'b0;
				blinks_n  = '0;
			end
		end

		if (restart) begin
			duty_n      = '0;
			ramp_down_n = 1'b0;
			lit_n       = 1'b0;
			elapsed_n   = '0;
			length_n    = '0;
			blink_n     = 1'b1;
			gap_act_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= '0;
			ramp_down_q <= 1'b0;
			lit_q       <= 1'b0;
			elapsed_q   <= '0;
			length_q    <= '0;
			blink_q     <= 1'b0;
			seq_q       <= 1'b0;
			blinks_q    <= '0;
			gap_act_q   <= 1'b0;
			gap_left_q  <= '0;
			presc_q     <= '0;
		end else begin
			duty_q      <= duty_n;
			ramp_down_q <= ramp_down_n;
			lit_q       <= lit_n;
			elapsed_q   <= elapsed_n;
			length_q    <= length_n;
			blink_q     <= blink_n;
			seq_q       <= seq_n;
			blinks_q    <= blinks_n;
			gap_act_q   <= gap_act_n;
			gap_left_q  <= gap_left_n;
			presc_q     <= presc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// The result reflects the state after this word's update.
	always_ff @(posedge clk) begin
		if (fire) begin
			led_q  <= lit_n ? (LED_W'(1) << select_q) : '0;
			busy_q <= seq_n;
		end
	end

	assign out_valid = out_valid_q;
	assign led_lines = led_q;
	assign busy_res  = busy_q;

`ifndef ASSERT_OFF
	a_blink_in_seq : assert property (@(posedge clk) disable iff (!arst_n)
		blink_q |-> seq_q)
		else $error("blink running outside a sequence");

	a_gap_excl : assert property (@(posedge clk) disable iff (!arst_n)
		!(blink_q && gap_act_q))
		else $error("blink and gap active together");

	a_phase_bound : assert property (@(posedge clk) disable iff (!arst_n)
		blink_q |-> (elapsed_q <= length_q))
		else $error("phase counter beyond phase length");

	a_stall_src : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire
